// File: hdl/rar_pkg.sv
// shared types, widths and codes for the rational arithmetic reduction block
package rar_pkg;

  // operand width of the four fraction fields
  localparam int OPERAND_W = 16;
  // magnitude of a cross product or of their sum
  localparam int PROD_W    = 2 * OPERAND_W;
  // counter width, holds PROD_W itself
  localparam int CNT_W     = $clog2(PROD_W + 1);
  // wide enough for the result clamps at 2^31
  localparam int EXT_W     = (PROD_W > 33) ? PROD_W : 33;

  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                  command;
    logic signed [OPERAND_W-1:0] num_a;
    logic signed [OPERAND_W-1:0] den_a;
    logic signed [OPERAND_W-1:0] num_b;
    logic signed [OPERAND_W-1:0] den_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        status;
  } out_beat_t;

  // which cross product the shared multiplier forms
  typedef enum logic [1:0] {
    MSEL_T0,
    MSEL_T1,
    MSEL_DEN
  } mul_sel_t;

  // kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_OK,
    RES_ERR,
    RES_ZERO
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      sum_en;
    logic      gcd_init;
    logic      gcd_step;
    logic      g_form;
    logic      div_init;
    logic      div_den;
    logic      div_step;
    logic      out_load;
    res_kind_t out_kind;
  } rar_cmd_t;

  typedef struct packed {
    logic den_zero_in;
    logic rn_zero;
    logic rd_zero;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } rar_sts_t;

endpackage

// File: hdl/rar_dp.sv
// datapath: operand decode, shared multiplier, sign-magnitude add, binary gcd, divider, output register
module rar_dp (
  input  logic                clk,
  input  logic                rst,
  input  rar_pkg::in_beat_t   in_beat,
  input  rar_pkg::rar_cmd_t   cmd,
  output rar_pkg::rar_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output rar_pkg::out_beat_t  out_beat
);

  localparam int W  = rar_pkg::OPERAND_W;
  localparam int PW = rar_pkg::PROD_W;
  localparam int CW = rar_pkg::CNT_W;
  localparam int EW = rar_pkg::EXT_W;
  localparam logic [EW-1:0] NEG_LIM = EW'(64'h8000_0000);
  localparam logic [EW-1:0] POS_LIM = EW'(64'h7FFF_FFFF);

  // operand registers, sign and magnitude
  logic [1:0]   op_cmd;
  logic         na_neg, da_neg, nb_neg, db_neg;
  logic [W-1:0] na_mag, da_mag, nb_mag, db_mag;

  // cross products: p becomes the raw numerator, d the raw denominator
  logic          p_neg, q_neg, d_neg;
  logic [PW-1:0] p_mag, q_mag, d_mag;

  // gcd and divider
  logic [PW-1:0] u, v, g;
  logic [CW-1:0] k;
  logic [PW-1:0] rem, quo, nm;
  logic [CW-1:0] div_cnt;

  logic [W-1:0]  mul_x, mul_y;
  logic          mul_xn, mul_yn, mul_flip;
  logic [PW-1:0] prod;
  logic          prod_neg;
  logic [PW:0]   rem_sh;

  logic               res_neg;
  logic [EW-1:0]      nm_e, nm_c, neg_e, dm_e, dm_c;
  rar_pkg::out_beat_t ok_beat;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    mag_of = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_x    = '0;
    mul_y    = '0;
    mul_xn   = 1'b0;
    mul_yn   = 1'b0;
    mul_flip = 1'b0;
    unique case (cmd.mul_sel)
      rar_pkg::MSEL_T0: begin
        mul_x  = na_mag;
        mul_xn = na_neg;
        mul_y  = (op_cmd == rar_pkg::CMD_MUL) ? nb_mag : db_mag;
        mul_yn = (op_cmd == rar_pkg::CMD_MUL) ? nb_neg : db_neg;
      end
      rar_pkg::MSEL_T1: begin
        // second cross product only for add and subtract
        mul_x    = (op_cmd == rar_pkg::CMD_ADD || op_cmd == rar_pkg::CMD_SUB) ? da_mag : '0;
        mul_xn   = da_neg;
        mul_y    = nb_mag;
        mul_yn   = nb_neg;
        mul_flip = (op_cmd == rar_pkg::CMD_SUB);
      end
      rar_pkg::MSEL_DEN: begin
        mul_x  = da_mag;
        mul_xn = da_neg;
        mul_y  = (op_cmd == rar_pkg::CMD_DIV) ? nb_mag : db_mag;
        mul_yn = (op_cmd == rar_pkg::CMD_DIV) ? nb_neg : db_neg;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign prod     = PW'(mul_x) * PW'(mul_y);
  assign prod_neg = (mul_xn ^ mul_yn ^ mul_flip) && (mul_x != '0) && (mul_y != '0);

  assign rem_sh = {rem, quo[PW-1]};

  // result formation for a good result
  always_comb begin
    res_neg = p_neg ^ d_neg;
    nm_e    = EW'(nm);
    dm_e    = EW'(quo);
    if (res_neg) begin
      nm_c = (nm_e > NEG_LIM) ? NEG_LIM : nm_e;
    end else begin
      nm_c = (nm_e > POS_LIM) ? POS_LIM : nm_e;
    end
    neg_e = res_neg ? ('0 - nm_c) : nm_c;
    dm_c  = (dm_e > POS_LIM) ? POS_LIM : dm_e;
    ok_beat.res_num = signed'(neg_e[rar_pkg::RES_NUM_W-1:0]);
    ok_beat.res_den = dm_c[rar_pkg::RES_DEN_W-1:0];
    ok_beat.status  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd <= in_beat.command;
      na_neg <= in_beat.num_a[W-1];
      da_neg <= in_beat.den_a[W-1];
      nb_neg <= in_beat.num_b[W-1];
      db_neg <= in_beat.den_b[W-1];
      na_mag <= mag_of(in_beat.num_a);
      da_mag <= mag_of(in_beat.den_a);
      nb_mag <= mag_of(in_beat.num_b);
      db_mag <= mag_of(in_beat.den_b);
    end

    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        rar_pkg::MSEL_T0: begin
          p_mag <= prod;
          p_neg <= prod_neg;
        end
        rar_pkg::MSEL_T1: begin
          q_mag <= prod;
          q_neg <= prod_neg;
        end
        rar_pkg::MSEL_DEN: begin
          d_mag <= prod;
          d_neg <= prod_neg;
        end
        default: begin
          d_mag <= d_mag;
        end
      endcase
    end

    // sign-magnitude sum, numerator lands back in p
    if (cmd.sum_en) begin
      if (p_neg == q_neg) begin
        p_mag <= p_mag + q_mag;
      end else if (p_mag >= q_mag) begin
        p_mag <= p_mag - q_mag;
      end else begin
        p_mag <= q_mag - p_mag;
        p_neg <= q_neg;
      end
    end

    if (cmd.gcd_init) begin
      u <= p_mag;
      v <= d_mag;
      k <= '0;
    end else if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= v;
        v <= u - v;
      end else begin
        v <= v - u;
      end
    end

    if (cmd.g_form) begin
      g <= u << k;
    end

    // restoring divider, one quotient bit a cycle
    if (cmd.div_init) begin
      rem     <= '0;
      div_cnt <= '0;
      quo     <= cmd.div_den ? d_mag : p_mag;
      if (cmd.div_den) begin
        nm <= quo;
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, g}) begin
        rem <= PW'(rem_sh - {1'b0, g});
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[PW-1:0];
        quo <= {quo[PW-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      case (cmd.out_kind)
        rar_pkg::RES_OK: begin
          out_beat <= ok_beat;
        end
        rar_pkg::RES_ZERO: begin
          out_beat.res_num <= '0;
          out_beat.res_den <= rar_pkg::RES_DEN_W'(1);
          out_beat.status  <= 1'b0;
        end
        default: begin
          out_beat.res_num <= '0;
          out_beat.res_den <= '0;
          out_beat.status  <= 1'b1;
        end
      endcase
    end

    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.den_zero_in = (da_mag == '0) || (db_mag == '0);
  assign sts.rn_zero     = (p_mag == '0);
  assign sts.rd_zero     = (d_mag == '0);
  assign sts.gcd_done    = (v == '0);
  assign sts.div_done    = (div_cnt == CW'(PW));
  assign sts.out_free    = !out_valid || !out_stall;

  a_gcd_step_live: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_step |-> v != '0)
    else $error("gcd step with v already zero");

  a_num_div_exact: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init && cmd.div_den |-> rem == '0)
    else $error("numerator not divisible by gcd");

  a_den_div_exact: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && cmd.out_kind == rar_pkg::RES_OK |-> rem == '0)
    else $error("denominator not divisible by gcd");

  a_err_beat_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.status |-> out_beat.res_num == '0 && out_beat.res_den == '0)
    else $error("error beat carries nonzero fields");

endmodule

// File: hdl/rar_ctrl.sv
// controller: sequences multiply, sum, gcd, the two divisions and the output load
module rar_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rar_pkg::rar_sts_t  sts,
  output rar_pkg::rar_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_CHECK,
    S_GCD,
    S_GFORM,
    S_DINIT_N,
    S_DIVN,
    S_DINIT_D,
    S_DIVD,
    S_OUT
  } state_t;

  state_t             state, state_next;
  rar_pkg::res_kind_t kind, kind_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mul_sel  = rar_pkg::MSEL_T0;
    cmd.out_kind = kind;
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        if (sts.den_zero_in) begin
          kind_next  = rar_pkg::RES_ERR;
          state_next = S_OUT;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = rar_pkg::MSEL_T0;
          state_next  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MSEL_T1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MSEL_DEN;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.rd_zero) begin
          kind_next  = rar_pkg::RES_ERR;
          state_next = S_OUT;
        end else if (sts.rn_zero) begin
          kind_next  = rar_pkg::RES_ZERO;
          state_next = S_OUT;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          state_next = S_GFORM;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GFORM: begin
        cmd.g_form = 1'b1;
        state_next = S_DINIT_N;
      end
      S_DINIT_N: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIVN;
      end
      S_DIVN: begin
        if (sts.div_done) begin
          state_next = S_DINIT_D;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DINIT_D: begin
        cmd.div_init = 1'b1;
        cmd.div_den  = 1'b1;
        state_next   = S_DIVD;
      end
      S_DIVD: begin
        if (sts.div_done) begin
          kind_next  = rar_pkg::RES_OK;
          state_next = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= rar_pkg::RES_OK;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_init |-> !sts.rd_zero && !sts.rn_zero)
    else $error("gcd started on a zero value");

endmodule

// File: hdl/rational_arith_reduce.sv
// top level of the rational arithmetic reduction block
//
//   channel   direction  handshake            beat
//   in        receive    in_valid/in_stall    in_beat  (command, num_a, den_a, num_b, den_b)
//   out       send       out_valid/out_stall  out_beat (res_num, res_den, status)
//
// one beat in flight; a new beat is taken only once the last result is loaded into the output register
// the binary gcd loop runs until v is zero, then come the two 32-step divisions by the gcd
// a zero operand denominator goes straight to the output load, a zero result skips the gcd and the divisions
// rst is synchronous; it clears the controller state and the output valid
// a waiting result sits in the output register, so the next beat is taken meanwhile
module rational_arith_reduce (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rar_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output rar_pkg::out_beat_t  out_beat
);

  // command and status between sequencer and datapath
  rar_pkg::rar_cmd_t cmd;
  rar_pkg::rar_sts_t sts;

  // sequencer: multiply, sum, gcd, divide, load result
  rar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath with the output register
  rar_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule
